// ===== hdl/tpss_pkg.sv =====
// Shared widths, codes, reset values and the job word for the touch point scan and scale block.
package tpss_pkg;

   // Field widths
   localparam int SAMPLE_W    = 12;
   localparam int SIZE_W      = 16;
   localparam int PRESS_W     = 13;
   localparam int STEP_W      = 2;
   localparam int COUNT_W     = 4;
   localparam int ACC_W       = 16;
   localparam int PROD_W      = SAMPLE_W + SIZE_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int AVERAGE_COUNT_DEFAULT = 10;

   // Full-scale ADC code
   localparam logic [SAMPLE_W-1:0] ADC_FULL = 12'd4095;

   // Calibration reset values
   localparam logic [SAMPLE_W-1:0] X_RAW_MIN_RESET = 12'd200;
   localparam logic [SAMPLE_W-1:0] X_RAW_MAX_RESET = 12'd3800;
   localparam logic [SAMPLE_W-1:0] Y_RAW_MIN_RESET = 12'd250;
   localparam logic [SAMPLE_W-1:0] Y_RAW_MAX_RESET = 12'd3700;
   localparam logic [SIZE_W-1:0]   WIDTH_Q8_RESET  = 16'd44032;
   localparam logic [SIZE_W-1:0]   HEIGHT_Q8_RESET = 16'd12800;

   // Scan steps
   localparam logic [STEP_W-1:0] STEP_X  = 2'd0;
   localparam logic [STEP_W-1:0] STEP_Y  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_Z1 = 2'd2;
   localparam logic [STEP_W-1:0] STEP_Z2 = 2'd3;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_X_RAW_MIN = 3'd0,
      CSR_X_RAW_MAX = 3'd1,
      CSR_Y_RAW_MIN = 3'd2,
      CSR_Y_RAW_MAX = 3'd3,
      CSR_WIDTH_Q8  = 3'd4,
      CSR_HEIGHT_Q8 = 3'd5
   } csr_index_type;

   // What the back end has to do for one word
   typedef enum logic [1:0] {
      JOB_PLAIN = 2'd0,
      JOB_AXIS  = 2'd1,
      JOB_POINT = 2'd2
   } job_kind_type;

   // data: sample (plain axis), sum (filtered axis) or pressure (point)
   typedef struct packed {
      job_kind_type        kind;
      logic                axis_y;
      logic                filtered;
      logic [ACC_W-1:0]    data;
      logic [STEP_W-1:0]   next_step;
      logic                filter_on;
   } job_type;

endpackage

// ===== hdl/touch_point_scan_scale.sv =====
// Four-wire resistive touch scan: averages X/Y samples, takes pressure, scales to Q8.8 mm.
// Every request word (ADC sample or button level) gives exactly one response word. The front
// end turns each word it takes into a job for a four-entry queue, so up to four words are
// taken back to back while the back end is busy. A plain job (button, intermediate filtered
// sample, z1) or a finished axis (one sample, or the mean of AVERAGE_COUNT samples formed by a
// reciprocal multiply) reaches the response register in the cycle after it leaves the queue.
// For the z2 sample that completes a point, each axis in turn starts the single serial
// divider in the back end, runs its iterations and collects the quotient, or skips the
// division when the value is at or below the calibrated minimum or the calibration span is
// empty. Calibration registers are written through the csr port and take effect at once;
// the user must write them only while the block is idle, which the block does not enforce.
module touch_point_scan_scale import tpss_pkg::*; #(
   parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   req_button_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STEP_W-1:0]      rsp_next_step,
   output logic                   rsp_point_valid,
   output logic [SIZE_W-1:0]      rsp_x_mm_q8,
   output logic [SIZE_W-1:0]      rsp_y_mm_q8,
   output logic [PRESS_W-1:0]     rsp_pressure,
   output logic                   rsp_filter_on,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic [SAMPLE_W-1:0] x_raw_min_ff;
   logic [SAMPLE_W-1:0] x_raw_max_ff;
   logic [SAMPLE_W-1:0] y_raw_min_ff;
   logic [SAMPLE_W-1:0] y_raw_max_ff;
   logic [SIZE_W-1:0]   width_q8_ff;
   logic [SIZE_W-1:0]   height_q8_ff;

   logic    front_valid;
   logic    front_ready;
   job_type front_job;
   logic    back_valid;
   logic    back_ready;
   job_type back_job;

   // Calibration registers; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         x_raw_min_ff <= X_RAW_MIN_RESET;
         x_raw_max_ff <= X_RAW_MAX_RESET;
         y_raw_min_ff <= Y_RAW_MIN_RESET;
         y_raw_max_ff <= Y_RAW_MAX_RESET;
         width_q8_ff  <= WIDTH_Q8_RESET;
         height_q8_ff <= HEIGHT_Q8_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_X_RAW_MIN: x_raw_min_ff <= csr_write_data[SAMPLE_W-1:0];
            CSR_X_RAW_MAX: x_raw_max_ff <= csr_write_data[SAMPLE_W-1:0];
            CSR_Y_RAW_MIN: y_raw_min_ff <= csr_write_data[SAMPLE_W-1:0];
            CSR_Y_RAW_MAX: y_raw_max_ff <= csr_write_data[SAMPLE_W-1:0];
            CSR_WIDTH_Q8:  width_q8_ff  <= csr_write_data[SIZE_W-1:0];
            CSR_HEIGHT_Q8: height_q8_ff <= csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   tpss_front #(
      .AVERAGE_COUNT (AVERAGE_COUNT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_sample       (req_sample),
      .req_button_level (req_button_level),
      .job_valid        (front_valid),
      .job_ready        (front_ready),
      .job              (front_job)
   );

   tpss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_job    (back_job)
   );

   tpss_back #(
      .AVERAGE_COUNT (AVERAGE_COUNT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (back_valid),
      .job_ready       (back_ready),
      .job             (back_job),
      .x_raw_min       (x_raw_min_ff),
      .x_raw_max       (x_raw_max_ff),
      .y_raw_min       (y_raw_min_ff),
      .y_raw_max       (y_raw_max_ff),
      .width_q8        (width_q8_ff),
      .height_q8       (height_q8_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_next_step   (rsp_next_step),
      .rsp_point_valid (rsp_point_valid),
      .rsp_x_mm_q8     (rsp_x_mm_q8),
      .rsp_y_mm_q8     (rsp_y_mm_q8),
      .rsp_pressure    (rsp_pressure),
      .rsp_filter_on   (rsp_filter_on)
   );

endmodule

// ===== hdl/tpss_front.sv =====
// Front end: accepts words, tracks scan step, averaging and filter button, emits jobs.
module tpss_front import tpss_pkg::*; #(
   parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_button_level,
   output logic                job_valid,
   input  logic                job_ready,
   output job_type             job
);

   localparam logic [COUNT_W-1:0] AVG_LAST = COUNT_W'(AVERAGE_COUNT);

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SAMPLE_W-1:0] first_ff, first_in;
   logic                filter_mode_ff, filter_mode_in;
   logic                axis_filter_ff, axis_filter_in;
   logic                last_button_ff, last_button_in;

   logic                axis_filter_now;
   logic [ACC_W-1:0]    acc_sum;
   logic [COUNT_W-1:0]  count_next;
   logic [PRESS_W:0]    press_sum;

   assign req_ready = job_ready;
   assign job_valid = req_valid;

   assign axis_filter_now = (count_ff == '0) ? filter_mode_ff : axis_filter_ff;
   assign acc_sum         = acc_ff + ACC_W'(req_sample);
   assign count_next      = count_ff + 1'b1;
   assign press_sum       = (PRESS_W+1)'(ADC_FULL) + (PRESS_W+1)'(first_ff)
                            - (PRESS_W+1)'(req_sample);

   // Classify the word and work out the next state
   always_comb begin
      step_in        = step_ff;
      count_in       = count_ff;
      acc_in         = acc_ff;
      first_in       = first_ff;
      filter_mode_in = filter_mode_ff;
      axis_filter_in = axis_filter_ff;
      last_button_in = last_button_ff;
      job            = '0;
      job.kind       = JOB_PLAIN;

      if (req_opcode) begin
         // falling edge of the button flips the filter
         if (last_button_ff && !req_button_level) begin
            filter_mode_in = ~filter_mode_ff;
         end
         last_button_in = req_button_level;
      end else begin
         unique case (step_ff)
            STEP_X, STEP_Y: begin
               axis_filter_in = axis_filter_now;
               job.axis_y     = (step_ff == STEP_Y);
               if (axis_filter_now) begin
                  if (count_next >= AVG_LAST) begin
                     job.kind     = JOB_AXIS;
                     job.filtered = 1'b1;
                     job.data     = acc_sum;
                     acc_in       = '0;
                     count_in     = '0;
                     step_in      = step_ff + 1'b1;
                  end else begin
                     acc_in   = acc_sum;
                     count_in = count_next;
                  end
               end else begin
                  job.kind = JOB_AXIS;
                  job.data = ACC_W'(req_sample);
                  step_in  = step_ff + 1'b1;
               end
            end
            STEP_Z1: begin
               first_in = req_sample;
               step_in  = STEP_Z2;
            end
            default: begin
               job.kind = JOB_POINT;
               job.data = ACC_W'(press_sum[PRESS_W-1:0]);
               step_in  = STEP_X;
            end
         endcase
      end

      job.next_step = step_in;
      job.filter_on = filter_mode_in;
   end

   // Advance state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= STEP_X;
         count_ff       <= '0;
         acc_ff         <= '0;
         first_ff       <= '0;
         filter_mode_ff <= 1'b0;
         axis_filter_ff <= 1'b0;
         last_button_ff <= 1'b1;
      end else if (req_valid && req_ready) begin
         step_ff        <= step_in;
         count_ff       <= count_in;
         acc_ff         <= acc_in;
         first_ff       <= first_in;
         filter_mode_ff <= filter_mode_in;
         axis_filter_ff <= axis_filter_in;
         last_button_ff <= last_button_in;
      end
   end

endmodule

// ===== hdl/tpss_queue.sv =====
// Small job queue that decouples the front end from the back end.
module tpss_queue import tpss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hdl/tpss_div.sv =====
// Restoring serial divider: one quotient bit per cycle.
module tpss_div import tpss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [PROD_W-1:0]   dividend,
   input  logic [SAMPLE_W-1:0] divisor,
   output logic                done,
   output logic [PROD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SAMPLE_W-1:0] rem_ff;
   logic [SAMPLE_W-1:0] div_ff;
   logic [PROD_W-1:0]   quo_ff;

   logic [SAMPLE_W:0]   trial;
   logic [SAMPLE_W:0]   diff;
   logic                fits;

   assign trial    = {rem_ff, quo_ff[PROD_W-1]};
   assign fits     = (trial >= {1'b0, div_ff});
   assign diff     = trial - {1'b0, div_ff};
   assign done     = done_ff;
   assign quotient = quo_ff;

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Shift in one dividend bit, subtract where it fits
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], fits};
      end
   end

endmodule

// ===== hdl/tpss_back.sv =====
// Back end: averages, scales both axes to millimetres and drives the result register.
module tpss_back import tpss_pkg::*; #(
   parameter int AVERAGE_COUNT = AVERAGE_COUNT_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  job_type             job,
   input  logic [SAMPLE_W-1:0] x_raw_min,
   input  logic [SAMPLE_W-1:0] x_raw_max,
   input  logic [SAMPLE_W-1:0] y_raw_min,
   input  logic [SAMPLE_W-1:0] y_raw_max,
   input  logic [SIZE_W-1:0]   width_q8,
   input  logic [SIZE_W-1:0]   height_q8,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STEP_W-1:0]   rsp_next_step,
   output logic                rsp_point_valid,
   output logic [SIZE_W-1:0]   rsp_x_mm_q8,
   output logic [SIZE_W-1:0]   rsp_y_mm_q8,
   output logic [PRESS_W-1:0]  rsp_pressure,
   output logic                rsp_filter_on
);

   // Exact reciprocal of AVERAGE_COUNT for any 16-bit sum
   localparam int RECIP_SHIFT = ACC_W + $clog2(AVERAGE_COUNT);
   localparam int RECIP_W     = ACC_W + 2;
   localparam int AVG_PROD_W  = ACC_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((1 << RECIP_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV
   } state_type;

   state_type           state_ff;
   logic                axis_y_ff;
   logic [SAMPLE_W-1:0] raw_x_ff;
   logic [SAMPLE_W-1:0] raw_y_ff;
   logic [SIZE_W-1:0]   x_res_ff;
   logic [STEP_W-1:0]   hold_step_ff;
   logic                hold_filter_ff;
   logic [PRESS_W-1:0]  hold_press_ff;

   logic                rsp_valid_ff;
   logic [STEP_W-1:0]   next_step_ff;
   logic                point_valid_ff;
   logic [SIZE_W-1:0]   x_mm_ff;
   logic [SIZE_W-1:0]   y_mm_ff;
   logic [PRESS_W-1:0]  pressure_ff;
   logic                filter_on_ff;

   logic                take;
   logic [AVG_PROD_W-1:0] avg_product;
   logic [SAMPLE_W-1:0] axis_val;
   logic [SAMPLE_W-1:0] lo;
   logic [SAMPLE_W-1:0] hi;
   logic [SIZE_W-1:0]   size;
   logic [SAMPLE_W-1:0] v;
   logic                zero_case;
   logic [SAMPLE_W-1:0] span;
   logic [PROD_W-1:0]   product;
   logic [SIZE_W-1:0]   clamped;

   logic                div_start;
   logic [PROD_W-1:0]   div_dividend;
   logic [SAMPLE_W-1:0] div_divisor;
   logic                div_done;
   logic [PROD_W-1:0]   div_quotient;

   assign job_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take      = job_valid && job_ready;

   // Mean of a filtered axis by reciprocal multiplication, else the single sample
   assign avg_product = AVG_PROD_W'(job.data) * AVG_PROD_W'(RECIP_MULT);
   assign axis_val    = job.filtered ? avg_product[RECIP_SHIFT +: SAMPLE_W]
                                     : job.data[SAMPLE_W-1:0];

   // Select calibration of the axis being scaled
   assign lo        = axis_y_ff ? y_raw_min : x_raw_min;
   assign hi        = axis_y_ff ? y_raw_max : x_raw_max;
   assign size      = axis_y_ff ? height_q8 : width_q8;
   assign v         = axis_y_ff ? raw_y_ff  : raw_x_ff;
   assign zero_case = (hi <= lo) || (v <= lo);
   assign span      = hi - lo;
   assign product   = PROD_W'(v - lo) * PROD_W'(size);
   assign clamped   = (div_quotient > PROD_W'(size)) ? size : div_quotient[SIZE_W-1:0];

   // Feed the divider for scaling
   assign div_start    = (state_ff == ST_MUL) && !zero_case;
   assign div_dividend = product;
   assign div_divisor  = span;

   tpss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequence jobs and load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_y_ff    <= 1'b0;
         raw_x_ff     <= '0;
         raw_y_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  hold_step_ff   <= job.next_step;
                  hold_filter_ff <= job.filter_on;
                  hold_press_ff  <= job.data[PRESS_W-1:0];
                  unique case (job.kind)
                     JOB_AXIS: begin
                        // inverted value: 4095 - q equals ~q on 12 bits
                        if (job.axis_y) begin
                           raw_y_ff <= ~axis_val;
                        end else begin
                           raw_x_ff <= ~axis_val;
                        end
                        rsp_valid_ff   <= 1'b1;
                        next_step_ff   <= job.next_step;
                        point_valid_ff <= 1'b0;
                        x_mm_ff        <= '0;
                        y_mm_ff        <= '0;
                        pressure_ff    <= '0;
                        filter_on_ff   <= job.filter_on;
                     end
                     JOB_POINT: begin
                        axis_y_ff <= 1'b0;
                        state_ff  <= ST_MUL;
                     end
                     default: begin
                        rsp_valid_ff   <= 1'b1;
                        next_step_ff   <= job.next_step;
                        point_valid_ff <= 1'b0;
                        x_mm_ff        <= '0;
                        y_mm_ff        <= '0;
                        pressure_ff    <= '0;
                        filter_on_ff   <= job.filter_on;
                     end
                  endcase
               end
            end
            ST_MUL: begin
               // out-of-range or bad calibration gives zero, no division
               if (zero_case) begin
                  if (axis_y_ff) begin
                     rsp_valid_ff   <= 1'b1;
                     next_step_ff   <= hold_step_ff;
                     point_valid_ff <= 1'b1;
                     x_mm_ff        <= x_res_ff;
                     y_mm_ff        <= '0;
                     pressure_ff    <= hold_press_ff;
                     filter_on_ff   <= hold_filter_ff;
                     state_ff       <= ST_IDLE;
                  end else begin
                     x_res_ff  <= '0;
                     axis_y_ff <= 1'b1;
                  end
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  if (axis_y_ff) begin
                     rsp_valid_ff   <= 1'b1;
                     next_step_ff   <= hold_step_ff;
                     point_valid_ff <= 1'b1;
                     x_mm_ff        <= x_res_ff;
                     y_mm_ff        <= clamped;
                     pressure_ff    <= hold_press_ff;
                     filter_on_ff   <= hold_filter_ff;
                     state_ff       <= ST_IDLE;
                  end else begin
                     x_res_ff  <= clamped;
                     axis_y_ff <= 1'b1;
                     state_ff  <= ST_MUL;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_step   = next_step_ff;
   assign rsp_point_valid = point_valid_ff;
   assign rsp_x_mm_q8     = x_mm_ff;
   assign rsp_y_mm_q8     = y_mm_ff;
   assign rsp_pressure    = pressure_ff;
   assign rsp_filter_on   = filter_on_ff;

endmodule

// ===== hdl/tpss_checker.sv =====
// Port-level checks for the touch point scan and scale block, bound to the top level.
module tpss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_next_step,
   input logic        rsp_point_valid,
   input logic [15:0] rsp_x_mm_q8,
   input logic [15:0] rsp_y_mm_q8,
   input logic [12:0] rsp_pressure,
   input logic        rsp_filter_on
);

   // Stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_step)
         && $stable(rsp_point_valid) && $stable(rsp_x_mm_q8) && $stable(rsp_y_mm_q8)
         && $stable(rsp_pressure) && $stable(rsp_filter_on))
      else $error("stalled response word changed");

   // Words that close no point carry zero position and pressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_point_valid |-> rsp_x_mm_q8 == 16'd0 && rsp_y_mm_q8 == 16'd0
         && rsp_pressure == 13'd0)
      else $error("non-point word carries data");

   // A finished point wraps the scan back to the X plane
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_point_valid |-> rsp_next_step == 2'd0)
      else $error("point did not restart scan at X");

   // Reset empties the response register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind touch_point_scan_scale tpss_checker u_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for touch_point_scan_scale: directed and random scans checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import tpss_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_TAIL   = 100;
   localparam int AVG_COUNT    = AVERAGE_COUNT_DEFAULT;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_BUTTON = 1'b1
   } opcode_type;

   localparam logic BUTTON_PRESSED  = 1'b0;
   localparam logic BUTTON_RELEASED = 1'b1;

   // Indexes past the register list; writes to them must change nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef struct packed {
      logic [STEP_W-1:0]  next_step;
      logic               point_valid;
      logic [SIZE_W-1:0]  x_mm_q8;
      logic [SIZE_W-1:0]  y_mm_q8;
      logic [PRESS_W-1:0] pressure;
      logic               filter_on;
   } point_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_opcode;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   req_button_level;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [STEP_W-1:0]      rsp_next_step;
   logic                   rsp_point_valid;
   logic [SIZE_W-1:0]      rsp_x_mm_q8;
   logic [SIZE_W-1:0]      rsp_y_mm_q8;
   logic [PRESS_W-1:0]     rsp_pressure;
   logic                   rsp_filter_on;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Calibration as the block should hold it
   logic [SAMPLE_W-1:0] cal_x_min = X_RAW_MIN_RESET;
   logic [SAMPLE_W-1:0] cal_x_max = X_RAW_MAX_RESET;
   logic [SAMPLE_W-1:0] cal_y_min = Y_RAW_MIN_RESET;
   logic [SAMPLE_W-1:0] cal_y_max = Y_RAW_MAX_RESET;
   logic [SIZE_W-1:0]   cal_width = WIDTH_Q8_RESET;
   logic [SIZE_W-1:0]   cal_height = HEIGHT_Q8_RESET;

   // Scan state as the block should hold it
   logic [STEP_W-1:0]   scan_step = STEP_X;
   logic [COUNT_W-1:0]  avg_count = '0;
   logic [ACC_W-1:0]    avg_sum = '0;
   logic [SAMPLE_W-1:0] held_x = '0;
   logic [SAMPLE_W-1:0] held_y = '0;
   logic [SAMPLE_W-1:0] z1_hold = '0;
   logic                filter_mode = 1'b0;
   logic                axis_filtered = 1'b0;
   logic                button_last = BUTTON_RELEASED;

   point_word_type expected_words[$];
   point_word_type due_word;
   int             error_count = 0;
   int             cycle_count = 0;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;

   touch_point_scan_scale uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_sample       (req_sample),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_next_step    (rsp_next_step),
      .rsp_point_valid  (rsp_point_valid),
      .rsp_x_mm_q8      (rsp_x_mm_q8),
      .rsp_y_mm_q8      (rsp_y_mm_q8),
      .rsp_pressure     (rsp_pressure),
      .rsp_filter_on    (rsp_filter_on),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Map an inverted raw reading onto 0..size, zero when the span is empty or the reading is at or below the minimum
   function automatic logic [SIZE_W-1:0] scale_to_mm(logic [SAMPLE_W-1:0] v,
                                                     logic [SAMPLE_W-1:0] lo,
                                                     logic [SAMPLE_W-1:0] hi,
                                                     logic [SIZE_W-1:0] size);
      int unsigned num;
      int unsigned q;
      if (hi <= lo || v <= lo) return '0;
      num = (32'(v) - 32'(lo)) * 32'(size);
      q = num / (32'(hi) - 32'(lo));
      if (q > 32'(size)) return size;
      return q[SIZE_W-1:0];
   endfunction

   // Advance the scan state by one accepted word and queue the response it gives
   function automatic void predict_scan_word(logic op, logic [SAMPLE_W-1:0] smp, logic lvl);
      point_word_type res;
      logic [ACC_W-1:0] axis_val;
      logic axis_done;
      res = '0;
      axis_val = '0;
      axis_done = 1'b0;
      if (op == OP_BUTTON) begin
         if (button_last == BUTTON_RELEASED && lvl == BUTTON_PRESSED)
            filter_mode = ~filter_mode;
         button_last = lvl;
      end else if (scan_step == STEP_X || scan_step == STEP_Y) begin
         // latch the filter mode on the first sample of an axis
         if (avg_count == 0) axis_filtered = filter_mode;
         if (axis_filtered) begin
            avg_sum = avg_sum + ACC_W'(smp);
            avg_count = avg_count + 1'b1;
            if (avg_count >= AVG_COUNT) begin
               axis_val = avg_sum / ACC_W'(AVG_COUNT);
               avg_sum = '0;
               avg_count = '0;
               axis_done = 1'b1;
            end
         end else begin
            axis_val = ACC_W'(smp);
            axis_done = 1'b1;
         end
         if (axis_done) begin
            if (scan_step == STEP_X)
               held_x = ADC_FULL - axis_val[SAMPLE_W-1:0];
            else
               held_y = ADC_FULL - axis_val[SAMPLE_W-1:0];
            scan_step = scan_step + 1'b1;
         end
      end else if (scan_step == STEP_Z1) begin
         z1_hold = smp;
         scan_step = STEP_Z2;
      end else begin
         res.point_valid = 1'b1;
         res.x_mm_q8 = scale_to_mm(held_x, cal_x_min, cal_x_max, cal_width);
         res.y_mm_q8 = scale_to_mm(held_y, cal_y_min, cal_y_max, cal_height);
         res.pressure = PRESS_W'(32'(ADC_FULL) + 32'(z1_hold) - 32'(smp));
         scan_step = STEP_X;
      end
      res.next_step = scan_step;
      res.filter_on = filter_mode;
      expected_words.push_back(res);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted response word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("response word with nothing expected");
            error_count++;
         end else begin
            due_word = expected_words.pop_front();
            check_field("next_step", due_word.next_step, rsp_next_step);
            check_field("point_valid", due_word.point_valid, rsp_point_valid);
            check_field("x_mm_q8", due_word.x_mm_q8, rsp_x_mm_q8);
            check_field("y_mm_q8", due_word.y_mm_q8, rsp_y_mm_q8);
            check_field("pressure", due_word.pressure, rsp_pressure);
            check_field("filter_on", due_word.filter_on, rsp_filter_on);
         end
      end
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Send one word; entered and left at a falling edge with valid still high
   task automatic send_scan_word(logic op, logic [SAMPLE_W-1:0] smp, logic lvl);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_sample = smp;
      req_button_level = lvl;
      do @(posedge clock); while (!req_ready);
      predict_scan_word(op, smp, lvl);
      @(negedge clock);
   endtask

   // Hold off the request side until every response has come back
   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_X_RAW_MIN: cal_x_min = data[SAMPLE_W-1:0];
         CSR_X_RAW_MAX: cal_x_max = data[SAMPLE_W-1:0];
         CSR_Y_RAW_MIN: cal_y_min = data[SAMPLE_W-1:0];
         CSR_Y_RAW_MAX: cal_y_max = data[SAMPLE_W-1:0];
         CSR_WIDTH_Q8:  cal_width = data;
         CSR_HEIGHT_Q8: cal_height = data;
         default: ;
      endcase
   endtask

   // Write all six registers; junk in the upper bits of the 12-bit ones must be dropped
   task automatic set_calibration(logic [SAMPLE_W-1:0] x_lo, logic [SAMPLE_W-1:0] x_hi,
                                  logic [SAMPLE_W-1:0] y_lo, logic [SAMPLE_W-1:0] y_hi,
                                  logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      wait_idle();
      write_csr(CSR_X_RAW_MIN, {4'($urandom_range(15)), x_lo});
      write_csr(CSR_X_RAW_MAX, {4'($urandom_range(15)), x_hi});
      write_csr(CSR_Y_RAW_MIN, {4'($urandom_range(15)), y_lo});
      write_csr(CSR_Y_RAW_MAX, {4'($urandom_range(15)), y_hi});
      write_csr(CSR_WIDTH_Q8, w);
      write_csr(CSR_HEIGHT_Q8, h);
   endtask

   // Favor rail values and the exact calibration edges of the axis being scanned
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      lo = (scan_step == STEP_X) ? cal_x_min : cal_y_min;
      hi = (scan_step == STEP_X) ? cal_x_max : cal_y_max;
      case ($urandom_range(9))
         0: return '0;
         1: return ADC_FULL;
         2: return ADC_FULL - lo + SAMPLE_W'($urandom_range(2)) - 1'b1;
         3: return ADC_FULL - hi + SAMPLE_W'($urandom_range(2)) - 1'b1;
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic send_random_words(int count);
      repeat (count) begin
         if ($urandom_range(99) < 8)
            send_scan_word(OP_BUTTON, SAMPLE_W'($urandom_range(4095)), 1'($urandom_range(1)));
         else
            send_scan_word(OP_SAMPLE, pick_sample(), 1'($urandom_range(1)));
      end
   endtask

   // Unfiltered points at the rails: clamp to size, floor to zero, pressure extremes
   task automatic test_plain_points();
      send_scan_word(OP_SAMPLE, 12'd0, 1'b1);
      send_scan_word(OP_SAMPLE, 12'd4095, 1'b0);
      send_scan_word(OP_SAMPLE, 12'd4095, 1'b1);
      send_scan_word(OP_BUTTON, 12'd4095, BUTTON_RELEASED);
      send_scan_word(OP_SAMPLE, 12'd0, 1'b0);
      send_scan_word(OP_SAMPLE, 12'd4095, 1'b1);
      send_scan_word(OP_SAMPLE, 12'd0, 1'b0);
      send_scan_word(OP_SAMPLE, 12'd0, 1'b1);
      send_scan_word(OP_SAMPLE, 12'd4095, 1'b0);
   endtask

   // Press toggles the filter; a toggle inside an averaged axis waits for the next axis
   task automatic test_filter_toggle();
      send_scan_word(OP_BUTTON, 12'd0, BUTTON_RELEASED);
      send_scan_word(OP_BUTTON, 12'd0, BUTTON_PRESSED);
      send_scan_word(OP_BUTTON, 12'd4095, BUTTON_PRESSED);
      repeat (4) send_scan_word(OP_SAMPLE, 12'd4095, 1'b0);
      send_scan_word(OP_BUTTON, 12'd0, BUTTON_RELEASED);
      send_scan_word(OP_BUTTON, 12'd0, BUTTON_PRESSED);
      repeat (6) send_scan_word(OP_SAMPLE, 12'd1234, 1'b1);
      send_scan_word(OP_SAMPLE, 12'd2048, 1'b0);
      send_scan_word(OP_SAMPLE, 12'd100, 1'b1);
      send_scan_word(OP_SAMPLE, 12'd300, 1'b0);
      send_scan_word(OP_BUTTON, 12'd0, BUTTON_RELEASED);
   endtask

   // Widest span, reversed and empty spans, zero size, masked writes, spare indexes
   task automatic test_calibration_extremes();
      set_calibration(12'd0, 12'd4095, 12'd0, 12'd4095, 16'hFFFF, 16'hFFFF);
      send_random_words(40);
      set_calibration(12'd4095, 12'd0, 12'd2000, 12'd2000, 16'h0000, 16'h8000);
      send_random_words(40);
      wait_idle();
      write_csr(CSR_X_RAW_MIN, 16'hF064);
      write_csr(CSR_X_RAW_MAX, 16'hAFFF);
      write_csr(CSR_Y_RAW_MIN, 16'h5000);
      write_csr(CSR_Y_RAW_MAX, 16'h1800);
      write_csr(CSR_WIDTH_Q8, 16'h0001);
      write_csr(CSR_HEIGHT_Q8, 16'h7FFF);
      write_csr(CSR_SPARE_LOW, 16'($urandom_range(65535)));
      write_csr(CSR_SPARE_HIGH, 16'($urandom_range(65535)));
      send_random_words(40);
      set_calibration(X_RAW_MIN_RESET, X_RAW_MAX_RESET, Y_RAW_MIN_RESET, Y_RAW_MAX_RESET,
                      WIDTH_Q8_RESET, HEIGHT_Q8_RESET);
      send_random_words(40);
   endtask

   // Random scans in blocks, recalibrating between blocks
   task automatic test_random_scan(int tx_pct, int rx_pct, int blocks);
      logic [SAMPLE_W-1:0] lo;
      logic [SAMPLE_W-1:0] hi;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (blocks) begin
         lo = SAMPLE_W'($urandom_range(2000));
         hi = SAMPLE_W'($urandom_range(4095, 32'(lo) + 1));
         if ($urandom_range(7) == 0)
            set_calibration(hi, lo, SAMPLE_W'($urandom_range(4095)),
                            SAMPLE_W'($urandom_range(4095)),
                            SIZE_W'($urandom_range(65535)), SIZE_W'($urandom_range(65535)));
         else
            set_calibration(lo, hi, SAMPLE_W'($urandom_range(1500)),
                            SAMPLE_W'($urandom_range(4095, 2500)),
                            SIZE_W'($urandom_range(65535)), SIZE_W'($urandom_range(65535)));
         send_random_words(100);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SAMPLE;
      req_sample = '0;
      req_button_level = BUTTON_RELEASED;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_X_RAW_MIN;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      tx_idle_pct = 10;
      rx_idle_pct = 55;
      test_plain_points();
      test_filter_toggle();
      test_calibration_extremes();
      test_random_scan(10, 55, 4);
      test_random_scan(55, 10, 4);
      test_random_scan(0, 0, 4);

      // drain, then give stray words time to show up
      wait_idle();
      repeat (DRAIN_TAIL) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tpss_pkg.sv
hdl/tpss_front.sv
hdl/tpss_queue.sv
hdl/tpss_div.sv
hdl/tpss_back.sv
hdl/touch_point_scan_scale.sv
hdl/tpss_checker.sv
test/tb_top.sv
